// File: rtl/bset_pkg.sv
// Shared types, constants and register codes of the Burning Ship escape-time unit.
`timescale 1ns / 1ps

package bset_pkg;

  // Image geometry and iteration limit.
  localparam int unsigned IMAGE_WIDTH  = 1024;
  localparam int unsigned IMAGE_HEIGHT = 1024;
  localparam logic [9:0]  ITER_LIMIT   = 10'd1023;

  // Fixed-point layout: coordinates are Q4.28, squares are Q56.
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned MUL_W     = 32;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned PIX_DW    = 13;
  localparam int unsigned COORD_W   = 44;
  localparam int unsigned MAG_W     = 30;
  localparam int unsigned SQ_W      = 59;
  localparam int unsigned Z_W       = 34;

  localparam logic [PIX_DW-1:0] HALF_W = PIX_DW'(IMAGE_WIDTH / 2);
  localparam logic [PIX_DW-1:0] HALF_H = PIX_DW'(IMAGE_HEIGHT / 2);

  // Escape thresholds: 2.0 in Q28 and 4.0 in Q56.
  localparam logic [Z_W-1:0]  TWO_Q28  = Z_W'(64'd1 << (FRAC_BITS + 1));
  localparam logic [SQ_W:0]   FOUR_Q56 = (SQ_W + 1)'(64'd1 << (2 * FRAC_BITS + 2));

  // Configuration register indexes.
  localparam logic [2:0] CFG_STEP_RE   = 3'd0;
  localparam logic [2:0] CFG_STEP_IM   = 3'd1;
  localparam logic [2:0] CFG_OFFSET_RE = 3'd2;
  localparam logic [2:0] CFG_OFFSET_IM = 3'd3;
  localparam logic [2:0] CFG_MAX_ITER  = 3'd4;

  typedef struct packed {
    logic [9:0] pixel_row;
    logic [9:0] pixel_col;
  } in_t;

  typedef struct packed {
    logic [9:0] iter_count;
    logic       in_set;
    logic [3:0] palette_index;
  } out_t;

  typedef struct packed {
    logic [30:0]        step_re;
    logic [30:0]        step_im;
    logic signed [31:0] offset_re;
    logic signed [31:0] offset_im;
    logic [9:0]         max_iter;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

endpackage

// File: rtl/bset_mul.sv
// Shared signed 32x32 multiplier with a registered product.
`timescale 1ns / 1ps

module bset_mul (
  input  logic                                  clk,
  input  logic signed [bset_pkg::MUL_W-1:0]     op_a,
  input  logic signed [bset_pkg::MUL_W-1:0]     op_b,
  output logic signed [bset_pkg::PROD_W-1:0]    prod_r
);
  import bset_pkg::*;

  // One product per cycle, registered before any further use.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// File: rtl/bset_core.sv
// Sequencer and datapath that map a pixel to c and iterate the Burning Ship recurrence.
`timescale 1ns / 1ps

module bset_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  bset_pkg::in_t           pix,
  input  bset_pkg::cfg_t          cfg,
  input  logic                    out_free,
  output bset_pkg::core_stat_t    stat,
  output bset_pkg::out_t          res
);
  import bset_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CRE   = 4'd1;
  localparam logic [3:0] S_CIM   = 4'd2;
  localparam logic [3:0] S_INIT  = 4'd3;
  localparam logic [3:0] S_CROSS = 4'd4;
  localparam logic [3:0] S_UPD   = 4'd5;
  localparam logic [3:0] S_SQRE  = 4'd6;
  localparam logic [3:0] S_SQIM  = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic signed [COORD_W-1:0] C_MAX = COORD_W'(64'sd2147483647);
  localparam logic signed [COORD_W-1:0] C_MIN = COORD_W'(-64'sd2147483648);

  logic [3:0]              state_r, state_nxt;
  logic [9:0]              row_r, col_r, limit_r, n_r;
  logic signed [31:0]      c_re_r, c_im_r;
  logic [MAG_W-1:0]        ar_r, ai_r;
  logic [SQ_W-1:0]         sq_re_r, sq_im_r;

  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PIX_DW-1:0] dcol, drow;

  logic signed [31:0]       coord_off;
  logic signed [COORD_W-1:0] coord_v;
  logic signed [31:0]       coord_sat;

  logic signed [Z_W-1:0]    re_v, im_v;
  logic [Z_W-1:0]           re_mag, im_mag;
  logic                     z_big;
  logic [SQ_W:0]            sq_sum;
  logic                     sq_big;
  logic [9:0]               limit_eff;

  // Pixel offsets from the image center.
  assign dcol = $signed({3'b000, col_r} - HALF_W);
  assign drow = $signed({3'b000, row_r} - HALF_H);

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_CRE: begin
        op_a = MUL_W'(dcol);
        op_b = $signed({1'b0, cfg.step_re});
      end
      S_CIM: begin
        op_a = MUL_W'(drow);
        op_b = $signed({1'b0, cfg.step_im});
      end
      S_CROSS: begin
        op_a = $signed({2'b00, ar_r});
        op_b = $signed({2'b00, ai_r});
      end
      S_SQRE: begin
        op_a = $signed({2'b00, ar_r});
        op_b = $signed({2'b00, ar_r});
      end
      S_SQIM: begin
        op_a = $signed({2'b00, ai_r});
        op_b = $signed({2'b00, ai_r});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  bset_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (mul_p)
  );

  // Coordinate: product plus pan offset, saturated to signed Q4.28.
  assign coord_off = (state_r == S_CIM) ? cfg.offset_re : cfg.offset_im;
  assign coord_v   = mul_p[COORD_W-1:0] + {{(COORD_W-32){coord_off[31]}}, coord_off};

  always_comb begin
    if (coord_v > C_MAX) begin
      coord_sat = 32'sh7FFF_FFFF;
    end else if (coord_v < C_MIN) begin
      coord_sat = 32'sh8000_0000;
    end else begin
      coord_sat = coord_v[31:0];
    end
  end

  // New z from the stored squares and the cross product, with its magnitudes.
  assign re_v = $signed({3'b000, sq_re_r[SQ_W-1:FRAC_BITS]})
              - $signed({3'b000, sq_im_r[SQ_W-1:FRAC_BITS]})
              + {{(Z_W-32){c_re_r[31]}}, c_re_r};
  assign im_v = $signed({2'b00, mul_p[SQ_W-1:FRAC_BITS-1]})
              + {{(Z_W-32){c_im_r[31]}}, c_im_r};
  assign re_mag = re_v[Z_W-1] ? Z_W'(-re_v) : Z_W'(re_v);
  assign im_mag = im_v[Z_W-1] ? Z_W'(-im_v) : Z_W'(im_v);
  assign z_big  = (re_mag > TWO_Q28) || (im_mag > TWO_Q28);

  // Exact |z|^2 > 4 test in Q56.
  assign sq_sum = {1'b0, sq_re_r} + {1'b0, mul_p[SQ_W-1:0]};
  assign sq_big = sq_sum > FOUR_Q56;

  assign limit_eff = (cfg.max_iter > ITER_LIMIT) ? ITER_LIMIT : cfg.max_iter;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_CRE;
      S_CRE:   state_nxt = S_CIM;
      S_CIM:   state_nxt = S_INIT;
      S_INIT:  state_nxt = S_CROSS;
      S_CROSS: state_nxt = (n_r == limit_r) ? S_DONE : S_UPD;
      S_UPD:   state_nxt = z_big ? S_DONE : S_SQRE;
      S_SQRE:  state_nxt = S_SQIM;
      S_SQIM:  state_nxt = S_CHK;
      S_CHK:   state_nxt = sq_big ? S_DONE : S_CROSS;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          row_r   <= pix.pixel_row;
          col_r   <= pix.pixel_col;
          limit_r <= limit_eff;
        end
      end
      S_CIM:  c_re_r <= coord_sat;
      S_INIT: begin
        c_im_r  <= coord_sat;
        ar_r    <= '0;
        ai_r    <= '0;
        sq_re_r <= '0;
        sq_im_r <= '0;
        n_r     <= '0;
      end
      S_UPD: begin
        ar_r <= re_mag[MAG_W-1:0];
        ai_r <= im_mag[MAG_W-1:0];
      end
      S_SQIM: sq_re_r <= mul_p[SQ_W-1:0];
      S_CHK: begin
        sq_im_r <= mul_p[SQ_W-1:0];
        if (!sq_big) n_r <= n_r + 10'd1;
      end
      default: ;
    endcase
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);

  assign res.iter_count    = n_r;
  assign res.in_set        = (n_r == limit_r);
  assign res.palette_index = n_r[3:0];

endmodule

// File: rtl/burning_ship_escape_time_unit.sv
// Top level of the Burning Ship escape-time unit: configuration, handshakes, result register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  pixel_row, pixel_col
// out_      output     out_valid/out_stall iter_count, in_set, palette_index
// cfg_      input      cfg_we             cfg_index, cfg_wdata
//
// A pixel passes the setup states that map it to c, then the iteration states
// until the limit or the escape is detected, then the done state; its run grows
// with the count n, as the shared multiplier is used three times per iteration.
// Reset is synchronous and active low and loads the register reset values.
// A new pixel is taken while an earlier result still waits in the output
// register; the unit then holds its finished result until that one is taken.

module burning_ship_escape_time_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bset_pkg::in_t        in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bset_pkg::out_t       out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_wdata
);
  import bset_pkg::*;

  cfg_t       cfg_r;
  out_t       out_r;
  logic       out_valid_r;
  logic       out_free;
  logic       start;
  core_stat_t stat;
  out_t       res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_re   <= 31'd1048576;
      cfg_r.step_im   <= 31'd1048576;
      cfg_r.offset_re <= '0;
      cfg_r.offset_im <= '0;
      cfg_r.max_iter  <= 10'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_RE:   cfg_r.step_re   <= cfg_wdata[30:0];
        CFG_STEP_IM:   cfg_r.step_im   <= cfg_wdata[30:0];
        CFG_OFFSET_RE: cfg_r.offset_re <= cfg_wdata;
        CFG_OFFSET_IM: cfg_r.offset_im <= cfg_wdata;
        CFG_MAX_ITER:  cfg_r.max_iter  <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // Input transaction starts the core when it is idle.
  assign in_stall = !stat.idle;
  assign start    = in_valid && stat.idle;

  // Output slot is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;

  bset_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .pix      (in_data),
    .cfg      (cfg_r),
    .out_free (out_free),
    .stat     (stat),
    .res      (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= stat.done;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stat.done) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
